@@ rtl/eol_pkg.sv @@
// Shared constants and types of the elevator order logic.
`default_nettype none
package eol_pkg;

    localparam int FLOORS_DEF = 4;
    localparam int LAMP_W     = 12;
    localparam int LAMP_FLOORS = LAMP_W / 3;

    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_REACHED   = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_CHOOSE    = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB  = 2'd2;

    localparam logic signed [1:0] DIR_DOWN = -2'sd1;
    localparam logic signed [1:0] DIR_STOP = 2'sd0;
    localparam logic signed [1:0] DIR_UP   = 2'sd1;

    localparam logic CLEAR_DIR_ONLY = 1'b0;

    typedef struct packed {
        logic       set_en;
        logic [1:0] set_btn;
        logic       clr_all;
        logic       drop_en;
        logic [2:0] drop_mask;
    } table_cmd_t;

endpackage
`default_nettype wire

@@ rtl/elevator_order_logic_unit.sv @@
// Elevator order logic: order table, floor and direction under a scan sequencer.
// Each item runs EXEC, SCAN, APPLY, then DONE, which holds until the output is free.
// A new item is accepted only in IDLE, after the last one has left DONE; the
// one-floor-per-cycle scan collects orders above and below the current floor.
// A result waits in the output register while the next item is taken.
// Reset: order table empty, floor unknown, direction stop, clear_mode 0, no result.
`default_nettype none
module elevator_order_logic_unit
    import eol_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF,
    localparam int FLW = $clog2(FLOORS),
    localparam int CW  = $clog2(FLOORS + 1) + 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic [1:0]         s_floor_index,
    input  wire logic [1:0]         s_button_kind,
    input  wire logic               s_car_moving,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [1:0]       m_direction,
    output logic                    m_should_stop,
    output logic                    m_has_orders,
    output logic [LAMP_W-1:0]       m_order_lamps,
    output logic                    m_refused
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_APPLY = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]        op_reg;
    logic [1:0]        fl_reg;
    logic [1:0]        btn_reg;
    logic              moving_reg;
    logic              refused_reg, refused_next;
    logic [FLW-1:0]    cur_reg, cur_next;
    logic              known_reg, known_next;
    logic signed [1:0] dir_reg, dir_next;
    logic              clear_mode_reg;
    logic [CW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic              above_reg, above_next;
    logic              below_reg, below_next;
    logic              any_reg, any_next;

    logic              m_valid_reg;
    logic signed [1:0] m_dir_reg;
    logic              m_stop_reg;
    logic              m_orders_reg;
    logic [LAMP_W-1:0] m_lamps_reg;
    logic              m_refused_reg;

    table_cmd_t        cmd;
    logic [FLW-1:0]    wr_idx;
    logic [2:0]        scan_flags;
    logic [2:0]        cur_flags;
    logic [LAMP_W-1:0] lamps;

    logic [CW-1:0]     fl_ext;
    logic              fl_ok;
    logic [FLW-1:0]    fl_idx;
    logic [FLW-1:0]    top_idx;
    logic [FLW-1:0]    scan_idx;
    logic              scan_hit;
    logic              scan_last;
    logic              cur_nz;
    logic              stop_here;
    logic              out_free;

    assign fl_ext    = {{(CW-2){1'b0}}, fl_reg};
    assign fl_ok     = fl_ext < CW'(FLOORS);
    assign fl_idx    = fl_ext[FLW-1:0];
    assign top_idx   = FLW'(FLOORS - 1);
    assign scan_idx  = scan_cnt_reg[FLW-1:0];
    assign scan_hit  = scan_flags != 3'b000;
    assign scan_last = scan_cnt_reg == CW'(FLOORS - 1);
    assign cur_nz    = cur_flags != 3'b000;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = state_reg == S_IDLE;

    eol_order_table #(
        .FLOORS(FLOORS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .wr_idx     (wr_idx),
        .scan_idx   (scan_idx),
        .cur_idx    (cur_reg),
        .scan_flags (scan_flags),
        .cur_flags  (cur_flags),
        .lamps      (lamps)
    );

    always_comb begin
        if (!known_reg) begin
            stop_here = 1'b0;
        end else if (dir_reg == DIR_DOWN) begin
            stop_here = cur_flags[BTN_DOWN] || cur_flags[BTN_CAB] ||
                        cur_reg == '0 || !below_reg;
        end else if (dir_reg == DIR_UP) begin
            stop_here = cur_flags[BTN_UP] || cur_flags[BTN_CAB] ||
                        cur_reg == top_idx || !above_reg;
        end else begin
            stop_here = cur_nz;
        end
    end

    always_comb begin
        state_next    = state_reg;
        refused_next  = refused_reg;
        cur_next      = cur_reg;
        known_next    = known_reg;
        dir_next      = dir_reg;
        scan_cnt_next = scan_cnt_reg;
        above_next    = above_reg;
        below_next    = below_reg;
        any_next      = any_reg;
        cmd           = '0;
        wr_idx        = cur_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                refused_next  = 1'b0;
                scan_cnt_next = '0;
                above_next    = 1'b0;
                below_next    = 1'b0;
                any_next      = 1'b0;
                state_next    = S_SCAN;
                case (op_reg)
                    OP_ADD: begin
                        wr_idx = fl_idx;
                        if (!fl_ok || btn_reg > BTN_CAB ||
                            (btn_reg == BTN_UP && fl_idx == top_idx) ||
                            (btn_reg == BTN_DOWN && fl_idx == '0)) begin
                            refused_next = 1'b1;
                        end else begin
                            cmd.set_en  = 1'b1;
                            cmd.set_btn = btn_reg;
                        end
                    end
                    OP_REACHED: begin
                        if (!fl_ok) begin
                            refused_next = 1'b1;
                        end else begin
                            cur_next   = fl_idx;
                            known_next = 1'b1;
                        end
                    end
                    OP_CLEAR, OP_CHOOSE: begin
                        refused_next = moving_reg || !known_reg;
                    end
                    OP_CLEAR_ALL: begin
                        cmd.clr_all = 1'b1;
                    end
                    default: begin
                        refused_next = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (scan_hit) begin
                    any_next = 1'b1;
                    if (scan_idx > cur_reg) begin
                        above_next = 1'b1;
                    end
                    if (scan_idx < cur_reg) begin
                        below_next = 1'b1;
                    end
                end
                scan_cnt_next = scan_cnt_reg + CW'(1);
                if (scan_last) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                state_next = S_DONE;
                if (!refused_reg && op_reg == OP_CLEAR) begin
                    cmd.drop_en = 1'b1;
                    cmd.drop_mask[BTN_CAB] = 1'b1;
                    if (clear_mode_reg != CLEAR_DIR_ONLY || dir_reg == DIR_STOP) begin
                        cmd.drop_mask[BTN_UP]   = 1'b1;
                        cmd.drop_mask[BTN_DOWN] = 1'b1;
                    end else if (dir_reg == DIR_DOWN) begin
                        cmd.drop_mask[BTN_DOWN] = 1'b1;
                        cmd.drop_mask[BTN_UP]   = !below_reg;
                    end else begin
                        cmd.drop_mask[BTN_UP]   = 1'b1;
                        cmd.drop_mask[BTN_DOWN] = !above_reg;
                    end
                end else if (!refused_reg && op_reg == OP_CHOOSE) begin
                    if (!(above_reg || below_reg || cur_nz)) begin
                        dir_next = DIR_STOP;
                    end else if (dir_reg == DIR_DOWN) begin
                        dir_next = (below_reg && cur_reg != '0) ? DIR_DOWN : DIR_UP;
                    end else if (dir_reg == DIR_UP) begin
                        dir_next = (above_reg && cur_reg != top_idx) ? DIR_UP : DIR_DOWN;
                    end else if (above_reg) begin
                        dir_next = DIR_UP;
                    end else if (below_reg) begin
                        dir_next = DIR_DOWN;
                    end else begin
                        dir_next = DIR_STOP;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            refused_reg    <= 1'b0;
            cur_reg        <= '0;
            known_reg      <= 1'b0;
            dir_reg        <= DIR_STOP;
            clear_mode_reg <= 1'b0;
            scan_cnt_reg   <= '0;
            above_reg      <= 1'b0;
            below_reg      <= 1'b0;
            any_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            refused_reg  <= refused_next;
            cur_reg      <= cur_next;
            known_reg    <= known_next;
            dir_reg      <= dir_next;
            scan_cnt_reg <= scan_cnt_next;
            above_reg    <= above_next;
            below_reg    <= below_next;
            any_reg      <= any_next;
            if (cfg_wr_en) begin
                clear_mode_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_operation;
            fl_reg     <= s_floor_index;
            btn_reg    <= s_button_kind;
            moving_reg <= s_car_moving;
        end
        if (state_reg == S_DONE && out_free) begin
            m_dir_reg     <= dir_reg;
            m_stop_reg    <= stop_here;
            m_orders_reg  <= known_reg ? (above_reg || below_reg || cur_nz) : any_reg;
            m_lamps_reg   <= lamps;
            m_refused_reg <= refused_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_direction   = m_dir_reg;
    assign m_should_stop = m_stop_reg;
    assign m_has_orders  = m_orders_reg;
    assign m_order_lamps = m_lamps_reg;
    assign m_refused     = m_refused_reg;

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted item did not start execution");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && out_free |=> m_valid && state_reg == S_IDLE)
        else $error("finished item not loaded into output register");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> scan_cnt_reg < CW'(FLOORS))
        else $error("scan counter past last floor");

    a_unknown_no_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !known_reg |-> !m_should_stop)
        else $error("stop reported while floor unknown");

    a_dir_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_reg == DIR_UP || dir_reg == DIR_DOWN || dir_reg == DIR_STOP)
        else $error("illegal travel direction");

endmodule
`default_nettype wire

@@ rtl/eol_order_table.sv @@
// Order flag table: three flags per floor with set, drop and clear-all.
`default_nettype none
module eol_order_table
    import eol_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF,
    localparam int FLW = $clog2(FLOORS)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire table_cmd_t       cmd,
    input  wire logic [FLW-1:0]   wr_idx,
    input  wire logic [FLW-1:0]   scan_idx,
    input  wire logic [FLW-1:0]   cur_idx,
    output logic [2:0]            scan_flags,
    output logic [2:0]            cur_flags,
    output logic [LAMP_W-1:0]     lamps
);

    logic [2:0] flags_reg [FLOORS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int f = 0; f < FLOORS; f++) begin
                flags_reg[f] <= 3'b000;
            end
        end else if (cmd.clr_all) begin
            for (int f = 0; f < FLOORS; f++) begin
                flags_reg[f] <= 3'b000;
            end
        end else if (cmd.set_en) begin
            flags_reg[wr_idx] <= flags_reg[wr_idx] | (3'b001 << cmd.set_btn);
        end else if (cmd.drop_en) begin
            flags_reg[wr_idx] <= flags_reg[wr_idx] & ~cmd.drop_mask;
        end
    end

    assign scan_flags = flags_reg[scan_idx];
    assign cur_flags  = flags_reg[cur_idx];

    always_comb begin
        lamps = '0;
        for (int f = 0; f < LAMP_FLOORS; f++) begin
            if (f < FLOORS) begin
                lamps[3*f +: 3] = flags_reg[f];
            end
        end
    end

endmodule
`default_nettype wire
